### sv/mcd_pkg.sv
// shared types, character codes and morse tables for the morse text codec
`default_nettype none

package mcd_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] in_char;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } out_item_t;

    // one run of output characters, as classified by the front end
    typedef struct packed {
        logic       is_text;
        logic       lead_space;
        logic [2:0] sym_count;
        logic [3:0] symbols;
        logic [7:0] letter;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int LETTERS = 26;

    localparam logic       ACT_ENCODE  = 1'b0;
    localparam logic [2:0] MAX_SYMBOLS = 3'd4;
    localparam logic [2:0] OVERFLOW_LEN = 3'd5;

    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // symbol k of a code sits in bit k, 1 = dash
    localparam logic [2:0] CODE_LEN [LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [3:0] CODE_BITS [LETTERS] = '{
        4'b0010, 4'b0001, 4'b0101, 4'b0001, 4'b0000, 4'b0100, 4'b0011, 4'b0000,
        4'b0000, 4'b1110, 4'b0101, 4'b0010, 4'b0011, 4'b0001, 4'b0111, 4'b0110,
        4'b1011, 4'b0010, 4'b0000, 4'b0001, 4'b0100, 4'b1000, 4'b0110, 4'b1001,
        4'b1101, 4'b0011
    };

    function automatic logic [7:0] decode_code(input logic [2:0] len,
                                               input logic [3:0] bits);
        logic [7:0] ch;
        ch = CH_QUEST;
        for (int k = 0; k < LETTERS; k++) begin
            if (CODE_LEN[k] == len && CODE_BITS[k] == bits) begin
                ch = CH_UPPER_A + 8'(k);
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/mcd_front.sv
// front end: accepts characters, tracks line state, classifies them into output runs
`default_nettype none

module mcd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mcd_pkg::in_item_t item,
    input  wire mcd_pkg::q_stat_t q_stat,
    output logic                  push,
    output mcd_pkg::cmd_t         cmd
);
    import mcd_pkg::*;

    logic [3:0] sym_reg, sym_next;
    logic [2:0] len_reg, len_next;
    logic       emitted_reg, emitted_next;

    logic       accept;
    logic       hit;
    logic       flush;
    logic [7:0] ch_up;
    logic [4:0] idx;
    logic [3:0] psym;
    logic [2:0] plen;

    assign item_stall = q_stat.full;
    assign accept     = item_valid && !q_stat.full;

    always_comb
    begin
        sym_next     = sym_reg;
        len_next     = len_reg;
        emitted_next = emitted_reg;
        hit          = 1'b0;
        flush        = 1'b0;
        cmd          = '0;
        ch_up        = item.in_char;
        idx          = '0;
        psym         = sym_reg;
        plen         = len_reg;

        if (item.action == ACT_ENCODE)
        begin
            if (item.in_char >= CH_LOWER_A && item.in_char <= CH_LOWER_Z)
            begin
                ch_up = item.in_char - CASE_OFFSET;
            end
            if (ch_up >= CH_UPPER_A && ch_up <= CH_UPPER_Z)
            begin
                idx            = 5'(ch_up - CH_UPPER_A);
                hit            = 1'b1;
                cmd.is_text    = 1'b0;
                cmd.lead_space = emitted_reg;
                cmd.sym_count  = CODE_LEN[idx];
                cmd.symbols    = CODE_BITS[idx];
                emitted_next   = 1'b1;
            end
        end
        else
        begin
            if (item.in_char == CH_DOT || item.in_char == CH_DASH)
            begin
                if (plen < MAX_SYMBOLS)
                begin
                    if (item.in_char == CH_DASH)
                    begin
                        psym = psym | (4'b0001 << plen[1:0]);
                    end
                    plen = plen + 3'd1;
                end
                else
                begin
                    plen = OVERFLOW_LEN;
                end
            end
            flush = (item.in_char == CH_SPACE) || item.end_of_line;
            if (flush && plen != 3'd0)
            begin
                hit         = 1'b1;
                cmd.is_text = 1'b1;
                cmd.letter  = decode_code(plen, psym);
                plen        = '0;
                psym        = '0;
            end
            sym_next = psym;
            len_next = plen;
        end

        if (item.end_of_line)
        begin
            sym_next     = '0;
            len_next     = '0;
            emitted_next = 1'b0;
        end
    end

    assign push = accept && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg     <= '0;
            len_reg     <= '0;
            emitted_reg <= 1'b0;
        end
        else if (accept)
        begin
            sym_reg     <= sym_next;
            len_reg     <= len_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

`default_nettype wire

### sv/mcd_queue.sv
// short command queue between the front end and the character generator
`default_nettype none

module mcd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mcd_pkg::cmd_t cmd,
    input  wire logic          pop,
    output mcd_pkg::q_stat_t   q_stat,
    output mcd_pkg::cmd_t      head
);
    import mcd_pkg::*;

    cmd_t               entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/mcd_back.sv
// back end: expands queued runs into characters, one beat per unstalled cycle
`default_nettype none

module mcd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mcd_pkg::q_stat_t q_stat,
    input  wire mcd_pkg::cmd_t    head,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mcd_pkg::out_item_t    result
);
    import mcd_pkg::*;

    cmd_t       cur_reg;
    logic       busy_reg;
    logic       space_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic       out_free;
    logic       gen;
    logic       load;
    logic [7:0] gen_char;
    logic       gen_last;

    assign out_free = !out_valid_reg || !result_stall;
    assign gen      = busy_reg && out_free;

    always_comb
    begin
        if (cur_reg.is_text)
        begin
            gen_char = cur_reg.letter;
            gen_last = 1'b1;
        end
        else if (space_reg)
        begin
            gen_char = CH_SPACE;
            gen_last = 1'b0;
        end
        else
        begin
            gen_char = cur_reg.symbols[idx_reg] ? CH_DASH : CH_DOT;
            gen_last = (({1'b0, idx_reg} + 3'd1) == cur_reg.sym_count);
        end
    end

    // next run is picked up in the cycle the current one hands off its last beat
    assign load = !busy_reg || (gen && gen_last);
    assign pop  = load && !q_stat.empty;

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            out_reg.out_char    <= gen_char;
            out_reg.last_of_run <= gen_last;
        end
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            space_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (gen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (pop)
            begin
                busy_reg  <= 1'b1;
                space_reg <= head.lead_space;
                idx_reg   <= '0;
            end
            else if (gen)
            begin
                if (gen_last)
                begin
                    busy_reg <= 1'b0;
                end
                else if (space_reg)
                begin
                    space_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### sv/morse_text_codec.sv
// morse text codec top level: front end, command queue and character generator
//
// input channel (item_valid / item_stall / item): one ascii character per beat
// with an action bit (0 encode a letter, 1 decode a '.' or '-' symbol) and an
// end-of-line mark that clears the line state, flushing a pending code on decode.
// output channel (result_valid / result_stall / result): one character per beat;
// last_of_run is set on the final character caused by an input beat. input
// beats that cause nothing produce no output beat.
// the first character of a run passes the command queue, the generator's run
// register and the output register. the character generator sends one
// character per cycle while the receiver does not stall, so an encoded letter
// gives up to five characters (space and four symbols) and a decoded letter one.
// the front end takes a beat every cycle while the two-entry queue has room.
// reset clears the line state, the queue and the output register.
// when the receiver stalls, the output beat holds; the generator and then the
// queue fill, and item_stall rises once the queue is full.
`default_nettype none

module morse_text_codec (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire mcd_pkg::in_item_t item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output mcd_pkg::out_item_t     result
);
    import mcd_pkg::*;

    q_stat_t q_stat;
    cmd_t    cmd;
    cmd_t    head;
    logic    push;
    logic    pop;

    mcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (cmd)
    );

    mcd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd    (cmd),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    mcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // a taken beat that is not the end of its run is followed at once by the next
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last_of_run |=> result_valid)
        else $error("run broken before its last character");

    // a separating space never ends a run
    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_char == CH_SPACE |-> !result.last_of_run)
        else $error("space marked as last of run");

    // only morse symbols, spaces, letters or the unknown mark leave the block
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_char == CH_DOT || result.out_char == CH_DASH
            || result.out_char == CH_SPACE || result.out_char == CH_QUEST
            || (result.out_char >= CH_UPPER_A && result.out_char <= CH_UPPER_Z)))
        else $error("illegal output character");

    // the front end never pushes into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

### tb/sv/tb_morse_text_codec.sv
// self-checking testbench for the morse text codec: queued stimulus, line predictor, char checker
`default_nettype none

module tb_morse_text_codec;
    timeunit 1ns;
    timeprecision 1ps;

    import mcd_pkg::*;

    localparam logic ACT_DECODE  = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_WAIT  = 8;

    // dots and dashes per letter, padded with spaces on the right
    localparam logic [31:0] MORSE_TEXT [26] = '{
        ".-  ", "-...", "-.-.", "-.. ", ".   ", "..-.", "--. ", "....", "..  ",
        ".---", "-.- ", ".-..", "--  ", "-.  ", "--- ", ".--.", "--.-", ".-. ",
        "... ", "-   ", "..- ", "...-", ".-- ", "-..-", "-.--", "--.."
    };

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    in_item_t  stim_q [$];
    out_item_t exp_chars [$];

    logic [3:0] pend_dashes  = '0;
    logic [2:0] pend_count   = '0;
    logic       line_started = 1'b0;

    int send_idle_pct = 29;
    int recv_idle_pct = 55;
    int mismatches    = 0;
    int cycle_count   = 0;
    int queued        = 0;

    morse_text_codec u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    function automatic void push_char(input logic [7:0] c);
        out_item_t o;
        o.out_char    = c;
        o.last_of_run = 1'b0;
        exp_chars.push_back(o);
    endfunction

    // line state machine of the codec, run on every accepted beat
    function automatic void predict_chars(input in_item_t it);
        logic [7:0]  ch;
        logic [7:0]  sym;
        logic [7:0]  letter;
        logic [4:0]  li;
        logic [3:0]  dashes;
        logic [2:0]  count;
        logic        flush;
        int          first;
        out_item_t   o;
        first = exp_chars.size();
        ch    = it.in_char;
        flush = 1'b0;
        if (it.action == ACT_ENCODE)
        begin
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                ch = ch - CASE_OFFSET;
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            begin
                li = 5'(ch - CH_UPPER_A);
                if (line_started)
                    push_char(CH_SPACE);
                for (int i = 0; i < 4; i++)
                begin
                    sym = MORSE_TEXT[li][31 - 8 * i -: 8];
                    if (sym != CH_SPACE)
                        push_char(sym);
                end
                line_started = 1'b1;
            end
        end
        else
        begin
            if (ch == CH_DOT || ch == CH_DASH)
            begin
                if (pend_count < MAX_SYMBOLS)
                begin
                    if (ch == CH_DASH)
                        pend_dashes[pend_count[1:0]] = 1'b1;
                    pend_count = pend_count + 3'd1;
                end
                else
                    pend_count = OVERFLOW_LEN;
            end
            else if (ch == CH_SPACE)
                flush = 1'b1;
            if (it.end_of_line)
                flush = 1'b1;
            if (flush && pend_count != 0)
            begin
                letter = CH_QUEST;
                if (pend_count <= MAX_SYMBOLS)
                begin
                    for (int k = 0; k < 26; k++)
                    begin
                        dashes = '0;
                        count  = '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            sym = MORSE_TEXT[k][31 - 8 * i -: 8];
                            if (sym != CH_SPACE)
                            begin
                                if (sym == CH_DASH)
                                    dashes[i] = 1'b1;
                                count = count + 3'd1;
                            end
                        end
                        if (count == pend_count && dashes == pend_dashes)
                            letter = CH_UPPER_A + 8'(k);
                    end
                end
                push_char(letter);
                pend_dashes = '0;
                pend_count  = '0;
            end
        end
        if (it.end_of_line)
        begin
            pend_dashes  = '0;
            pend_count   = '0;
            line_started = 1'b0;
        end
        if (exp_chars.size() > first)
        begin
            o = exp_chars.pop_back();
            o.last_of_run = 1'b1;
            exp_chars.push_back(o);
        end
    endfunction

    // driver: a new beat is offered only once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                predict_chars(item);
            if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= stim_q.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (exp_chars.size() == 0)
                    report_mismatch("unexpected beat, char", result.out_char, 8'h00);
                else
                begin
                    out_item_t want;
                    want = exp_chars.pop_front();
                    if (result.out_char !== want.out_char)
                        report_mismatch("out_char", result.out_char, want.out_char);
                    if (result.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 8'(result.last_of_run),
                                        8'(want.last_of_run));
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic add_item(input logic act, input logic [7:0] ch, input logic eol);
        in_item_t it;
        it.action      = act;
        it.in_char     = ch;
        it.end_of_line = eol;
        stim_q.push_back(it);
        queued++;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CH_UPPER_A + 8'($urandom_range(25));
        if ($urandom_range(1))
            c = c + CASE_OFFSET;
        return c;
    endfunction

    task automatic gen_encode_line();
        int n;
        logic [7:0] c;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
                c = rand_letter();
            else
                c = 8'($urandom_range(255));
            add_item(ACT_ENCODE, c, i == n - 1);
        end
    endtask

    task automatic gen_decode_line();
        int groups;
        int len;
        int ending;
        groups = $urandom_range(4, 1);
        ending = $urandom_range(2);
        for (int g = 0; g < groups; g++)
        begin
            len = ($urandom_range(99) < 12) ? $urandom_range(7, 5) : $urandom_range(4, 1);
            for (int s = 0; s < len; s++)
            begin
                if ($urandom_range(99) < 5)
                    add_item(ACT_DECODE, 8'($urandom_range(255)), 1'b0);
                if ($urandom_range(99) < 4)
                    add_item(ACT_ENCODE, rand_letter(), 1'b0);
                add_item(ACT_DECODE, $urandom_range(1) ? CH_DASH : CH_DOT,
                         g == groups - 1 && s == len - 1 && ending == 0);
            end
            if (g < groups - 1)
            begin
                add_item(ACT_DECODE, CH_SPACE, 1'b0);
                if ($urandom_range(99) < 15)
                    add_item(ACT_DECODE, CH_SPACE, 1'b0);
            end
        end
        if (ending == 1)
            add_item(ACT_DECODE, CH_SPACE, 1'b1);
        else if (ending == 2)
            add_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic gen_random(input int count);
        int stop;
        int pick;
        stop = queued + count;
        while (queued < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                gen_encode_line();
            else if (pick < 85)
                gen_decode_line();
            else
                add_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                         $urandom_range(99) < 25);
        end
    endtask

    task automatic wait_drained();
        while (stim_q.size() > 0 || item_valid || exp_chars.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        // ignored first char, then a lowercase letter with no leading space
        add_item(ACT_ENCODE, 8'h00, 1'b0);
        add_item(ACT_ENCODE, "a", 1'b0);
        add_item(ACT_ENCODE, "Z", 1'b0);
        add_item(ACT_ENCODE, 8'hFF, 1'b1);
        add_item(ACT_ENCODE, "E", 1'b1);
        add_item(ACT_DECODE, CH_DOT, 1'b0);
        add_item(ACT_DECODE, CH_DASH, 1'b0);
        add_item(ACT_DECODE, CH_SPACE, 1'b0);
        // space with nothing pending
        add_item(ACT_DECODE, CH_SPACE, 1'b0);
        // overlong code flushed by end of line on an ignored char
        repeat (5) add_item(ACT_DECODE, CH_DOT, 1'b0);
        add_item(ACT_DECODE, 8'hFF, 1'b1);
        // unknown four-symbol code, flushed on its last symbol
        add_item(ACT_DECODE, CH_DOT, 1'b0);
        add_item(ACT_DECODE, CH_DOT, 1'b0);
        add_item(ACT_DECODE, CH_DASH, 1'b0);
        add_item(ACT_DECODE, CH_DASH, 1'b1);
        add_item(ACT_DECODE, 8'h00, 1'b1);
        // mixed modes: encode leaves the pending code alone, then drops it at end of line
        add_item(ACT_DECODE, CH_DASH, 1'b0);
        add_item(ACT_ENCODE, "T", 1'b0);
        add_item(ACT_DECODE, CH_DASH, 1'b0);
        add_item(ACT_ENCODE, "q", 1'b1);
        gen_random(90);

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sender holds off until every expected char is out
        wait_drained();
        send_idle_pct = 55;
        recv_idle_pct = 29;
        gen_random(110);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_random(110);

        wait_drained();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
